// ----- hdl/drc_pkg.sv -----
// Shared constants and types for the dynamic resolution controller.
package drc_pkg;

   localparam int TIME_W        = 18;
   localparam int SCALE_W       = 16;
   localparam int STEP_W        = 14;
   localparam int SETTLE_CFG_W  = 8;
   localparam int OUT_COUNT_W   = 32;
   localparam int COUNTER_WIDTH = 32;
   localparam int SETTLE_LIMIT  = 255;
   localparam int SETTLE_W      = $clog2(SETTLE_LIMIT + 1);
   localparam int SETTLE_CMP_W  = (SETTLE_W > SETTLE_CFG_W) ? SETTLE_W : SETTLE_CFG_W;

   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [SCALE_W-1:0] SCALE_ONE  = 16'd32768;
   localparam logic [SCALE_W-1:0] MIN_FLOOR  = 16'd16384;
   localparam logic [STEP_W-1:0]  STEP_LOW   = 14'd328;
   localparam logic [STEP_W-1:0]  STEP_HIGH  = 14'd8192;
   localparam logic [TIME_W-1:0]  TARGET_LOW  = 18'd256;
   localparam logic [TIME_W-1:0]  TARGET_HIGH = 18'd256000;
   localparam logic [15:0]        EMA_WEIGHT  = 16'd9830;
   localparam logic [15:0]        EMA_KEEP    = 16'd55706;
   localparam logic [SCALE_W:0]   CHANGE_MIN  = 17'd164;

   localparam logic [TIME_W-1:0]       RST_TARGET = 18'd4267;
   localparam logic [SCALE_W-1:0]      RST_MIN    = 16'd16384;
   localparam logic [STEP_W-1:0]       RST_STEP   = 14'd1638;
   localparam logic [SETTLE_CFG_W-1:0] RST_SETTLE = 8'd1;
   localparam logic [SCALE_W-1:0]      RST_INIT   = 16'd32768;

   typedef enum logic [2:0] {
      REG_ENABLED  = 3'd0,
      REG_TARGET   = 3'd1,
      REG_MIN      = 3'd2,
      REG_STEP     = 3'd3,
      REG_SETTLE   = 3'd4,
      REG_INIT     = 3'd5
   } drc_reg_type;

endpackage

// ----- hdl/drc_req_if.sv -----
// Input channel carrying one frame time sample per beat.
interface drc_req_if
   import drc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] frame_time;

   modport source (output valid, output frame_time, input ready);
   modport sink   (input valid, input frame_time, output ready);
endinterface

// ----- hdl/drc_rsp_if.sv -----
// Result channel carrying the render scale, filtered time and counters per beat.
interface drc_rsp_if
   import drc_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [SCALE_W-1:0]     frame_scale;
   logic [TIME_W-1:0]      average_frame_time;
   logic [OUT_COUNT_W-1:0] overload_count;
   logic [OUT_COUNT_W-1:0] headroom_count;
   logic [OUT_COUNT_W-1:0] change_count;

   modport source (output valid, output frame_scale, output average_frame_time,
                   output overload_count, output headroom_count, output change_count,
                   input ready);
   modport sink   (input valid, input frame_scale, input average_frame_time,
                   input overload_count, input headroom_count, input change_count,
                   output ready);
endinterface

// ----- hdl/dynamic_resolution_controller_core.sv -----
// Dynamic resolution controller: frame time filter, scale decision and register file.
//
//   Channel   Direction  Contents
//   req_bus   in         frame_time sample, valid/ready
//   rsp_bus   out        frame_scale, average_frame_time, three counters, valid/ready
//   csr       in/out     APB-style register port, six registers at 4*index
//
// One beat is accepted every cycle while rsp_bus is not stalled; its result is offered
// on rsp_bus through an input register and a result register.
// The filter, threshold compare and scale step all work combinationally from the
// input register, so the next beat sees the updated state at once.
// Reset is synchronous and restores register defaults, a full scale and cleared counters.
// A stalled result holds both stages; the input register still takes a beat while empty.
module dynamic_resolution_controller_core
   import drc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   drc_req_if.sink               req_bus,
   drc_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic                    enabled_ff;
   logic [TIME_W-1:0]       target_ff;
   logic [SCALE_W-1:0]      min_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [SETTLE_CFG_W-1:0] settle_ff;
   logic [SCALE_W-1:0]      init_ff;

   logic [TIME_W-1:0]        avg_ff,    avg_in;
   logic                     seeded_ff, seeded_in;
   logic [SETTLE_W-1:0]      fs_ff,     fs_in;
   logic [SCALE_W-1:0]       scale_ff,  scale_in;
   logic [COUNTER_WIDTH-1:0] over_ff,   over_in;
   logic [COUNTER_WIDTH-1:0] room_ff,   room_in;
   logic [COUNTER_WIDTH-1:0] change_ff, change_in;

   logic              s1_valid_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic              out_valid_ff;
   logic              advance;
   logic              step_now;
   logic              csr_write;
   logic              init_write;
   drc_reg_type       csr_index;

   logic [SCALE_W-1:0]  eff_min;
   logic [TIME_W-1:0]   eff_target;
   logic [STEP_W-1:0]   eff_step;
   logic [SCALE_W-1:0]  restart_scale;
   logic [TIME_W+16:0]  ema_acc;
   logic [SETTLE_W-1:0] fs_inc;
   logic [SETTLE_CFG_W-1:0] settle_eff;
   logic [TIME_W+6:0]   avg_x100;
   logic [TIME_W+6:0]   target_x105;
   logic [TIME_W+2:0]   avg_x5;
   logic [TIME_W+2:0]   target_x4;
   logic [SCALE_W:0]    next_scale;
   logic [SCALE_W:0]    diff;

   assign advance        = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !s1_valid_ff || advance;
   assign step_now       = s1_valid_ff && advance;
   assign pready         = 1'b1;
   assign csr_write      = psel && penable && pwrite;
   assign csr_index      = drc_reg_type'(paddr[4:2]);
   assign init_write     = csr_write && (csr_index == REG_INIT);

   always_comb begin
      eff_min = min_ff;
      if (min_ff < MIN_FLOOR) begin
         eff_min = MIN_FLOOR;
      end else if (min_ff > SCALE_ONE) begin
         eff_min = SCALE_ONE;
      end
      eff_target = target_ff;
      if (target_ff < TARGET_LOW) begin
         eff_target = TARGET_LOW;
      end else if (target_ff > TARGET_HIGH) begin
         eff_target = TARGET_HIGH;
      end
      eff_step = step_ff;
      if (step_ff < STEP_LOW) begin
         eff_step = STEP_LOW;
      end else if (step_ff > STEP_HIGH) begin
         eff_step = STEP_HIGH;
      end
      restart_scale = pwdata[SCALE_W-1:0];
      if (pwdata[SCALE_W-1:0] < eff_min) begin
         restart_scale = eff_min;
      end else if (pwdata[SCALE_W-1:0] > SCALE_ONE) begin
         restart_scale = SCALE_ONE;
      end
   end

   always_comb begin
      avg_in    = avg_ff;
      seeded_in = seeded_ff;
      fs_in     = fs_ff;
      scale_in  = scale_ff;
      over_in   = over_ff;
      room_in   = room_ff;
      change_in = change_ff;

      ema_acc = (TIME_W+17)'(avg_ff) * (TIME_W+17)'(EMA_KEEP)
              + (TIME_W+17)'(s1_time_ff) * (TIME_W+17)'(EMA_WEIGHT)
              + (TIME_W+17)'(32768);
      fs_inc      = (fs_ff < SETTLE_W'(SETTLE_LIMIT)) ? fs_ff + 1'b1 : fs_ff;
      settle_eff  = (settle_ff == '0) ? RST_SETTLE : settle_ff;
      avg_x100    = '0;
      target_x105 = (TIME_W+7)'(eff_target) * (TIME_W+7)'(105);
      avg_x5      = '0;
      target_x4   = {1'b0, eff_target, 2'b00};
      next_scale  = {1'b0, scale_ff};
      diff        = '0;

      if (step_now && enabled_ff && s1_time_ff != '0) begin
         avg_in    = seeded_ff ? ema_acc[TIME_W+15:16] : s1_time_ff;
         seeded_in = 1'b1;
         fs_in     = fs_inc;
         avg_x100  = (TIME_W+7)'(avg_in) * (TIME_W+7)'(100);
         avg_x5    = (TIME_W+3)'(avg_in) * (TIME_W+3)'(5);
         if (SETTLE_CMP_W'(fs_inc) >= SETTLE_CMP_W'(settle_eff)) begin
            if (avg_x100 > target_x105) begin
               if (over_ff != COUNT_MAX) begin
                  over_in = over_ff + 1'b1;
               end
               next_scale = {1'b0, scale_ff} - (SCALE_W+1)'(eff_step);
            end else if (avg_x5 < target_x4) begin
               if (room_ff != COUNT_MAX) begin
                  room_in = room_ff + 1'b1;
               end
               next_scale = {1'b0, scale_ff} + (SCALE_W+1)'(eff_step);
            end
            if (next_scale < {1'b0, eff_min}) begin
               next_scale = {1'b0, eff_min};
            end else if (next_scale > {1'b0, SCALE_ONE}) begin
               next_scale = {1'b0, SCALE_ONE};
            end
            diff = (next_scale > {1'b0, scale_ff}) ? next_scale - {1'b0, scale_ff}
                                                   : {1'b0, scale_ff} - next_scale;
            if (diff >= CHANGE_MIN) begin
               scale_in = next_scale[SCALE_W-1:0];
               fs_in    = '0;
               if (change_ff != COUNT_MAX) begin
                  change_in = change_ff + 1'b1;
               end
            end
         end
      end

      if (init_write) begin
         scale_in  = restart_scale;
         avg_in    = '0;
         seeded_in = 1'b0;
         fs_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         target_ff    <= RST_TARGET;
         min_ff       <= RST_MIN;
         step_ff      <= RST_STEP;
         settle_ff    <= RST_SETTLE;
         init_ff      <= RST_INIT;
         avg_ff       <= '0;
         seeded_ff    <= 1'b0;
         fs_ff        <= '0;
         scale_ff     <= SCALE_ONE;
         over_ff      <= '0;
         room_ff      <= '0;
         change_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         avg_ff    <= avg_in;
         seeded_ff <= seeded_in;
         fs_ff     <= fs_in;
         scale_ff  <= scale_in;
         over_ff   <= over_in;
         room_ff   <= room_in;
         change_ff <= change_in;
         if (csr_write) begin
            case (csr_index)
               REG_ENABLED: enabled_ff <= pwdata[0];
               REG_TARGET:  target_ff  <= pwdata[TIME_W-1:0];
               REG_MIN:     min_ff     <= pwdata[SCALE_W-1:0];
               REG_STEP:    step_ff    <= pwdata[STEP_W-1:0];
               REG_SETTLE:  settle_ff  <= pwdata[SETTLE_CFG_W-1:0];
               REG_INIT:    init_ff    <= pwdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_time_ff <= req_bus.frame_time;
      end
      if (step_now) begin
         rsp_bus.frame_scale        <= scale_in;
         rsp_bus.average_frame_time <= avg_in;
         rsp_bus.overload_count     <= OUT_COUNT_W'(over_in);
         rsp_bus.headroom_count     <= OUT_COUNT_W'(room_in);
         rsp_bus.change_count       <= OUT_COUNT_W'(change_in);
      end
   end

   assign rsp_bus.valid = out_valid_ff;

   always_comb begin
      prdata = '0;
      case (csr_index)
         REG_ENABLED: prdata = CSR_DATA_W'(enabled_ff);
         REG_TARGET:  prdata = CSR_DATA_W'(target_ff);
         REG_MIN:     prdata = CSR_DATA_W'(min_ff);
         REG_STEP:    prdata = CSR_DATA_W'(step_ff);
         REG_SETTLE:  prdata = CSR_DATA_W'(settle_ff);
         REG_INIT:    prdata = CSR_DATA_W'(init_ff);
         default:     prdata = '0;
      endcase
   end

endmodule
